// File: src/rops_pkg.sv
// Shared constants, codes and types of the rectangle overlap pair scanner.
`default_nettype none
package rops_pkg;

    localparam int TABLE_SLOTS    = 8;
    localparam int IDX_W          = $clog2(TABLE_SLOTS);
    localparam int MAX_PAIR_ITEMS = 28;
    localparam int CNT_W          = $clog2(MAX_PAIR_ITEMS + 1);
    localparam int MASK_W         = 64;
    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_MARK = 2'd1,
        CMD_SCAN = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_FULL   = 3'd1,
        ST_MARKED = 3'd2,
        ST_PAIR   = 3'd3,
        ST_DONE   = 3'd4
    } t_status;

    typedef struct packed {
        logic        notify;
        logic [2:0]  kind;
        logic [14:0] h;
        logic [14:0] w;
        logic [15:0] y;
        logic [15:0] x;
    } t_entry;

    typedef struct packed {
        t_cmd       op;
        t_entry     entry;
        logic [3:0] slot;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// File: src/rops_front.sv
// Front end: accepts input transfers, drops unknown commands, packs queue items.
`default_nettype none
module rops_front (
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [15:0] i_rect_x,
    input  wire logic signed [15:0] i_rect_y,
    input  wire logic [14:0]        i_rect_w,
    input  wire logic [14:0]        i_rect_h,
    input  wire logic [2:0]         i_kind,
    input  wire logic               i_notify,
    input  wire logic [3:0]         i_slot,
    input  wire rops_pkg::t_q_stat  i_q_stat,
    output logic                    o_push,
    output rops_pkg::t_item         o_item
);
    import rops_pkg::*;

    t_cmd cmd;

    always_comb begin
        cmd               = t_cmd'(i_command);
        o_in_ready        = !i_q_stat.full;
        o_push            = i_in_valid && !i_q_stat.full && (cmd != CMD_NONE);
        o_item.op         = cmd;
        o_item.entry.notify = i_notify;
        o_item.entry.kind = i_kind;
        o_item.entry.h    = i_rect_h;
        o_item.entry.w    = i_rect_w;
        o_item.entry.y    = i_rect_y;
        o_item.entry.x    = i_rect_x;
        o_item.slot       = i_slot;
    end

endmodule
`default_nettype wire

// File: src/rops_fifo.sv
// Short command queue between the front end and the table engine.
`default_nettype none
module rops_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rops_pkg::t_item   i_item,
    input  wire logic              i_pop,
    output rops_pkg::t_item        o_item,
    output rops_pkg::t_q_stat      o_stat
);
    import rops_pkg::*;

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_wr_ptr;
    logic [Q_PTR_W-1:0]   n_rd_ptr;
    logic [Q_CNT_W-1:0]   n_count;
    logic                 do_push;
    logic                 do_pop;

    always_comb begin
        o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
        o_stat.empty = (r_count == '0);
        o_item       = r_mem[r_rd_ptr];
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_count      = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// File: src/rops_back.sv
// Table engine: add, mark, and pairwise overlap scan with a registered result.
`default_nettype none
module rops_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rops_pkg::MASK_W-1:0] i_cfg_data,
    input  wire rops_pkg::t_q_stat           i_q_stat,
    input  wire rops_pkg::t_item             i_item,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [2:0]                       o_status,
    output logic [3:0]                       o_given_slot,
    output logic [3:0]                       o_first_index,
    output logic [3:0]                       o_second_index,
    output logic                             o_first_reported,
    output logic                             o_second_reported,
    output logic                             o_last
);
    import rops_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PAIR = 3'b010,
        S_DONE = 3'b100
    } t_state;

    function automatic logic f_overlap(t_entry a, t_entry b);
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] aw;
        logic signed [17:0] ah;
        logic signed [17:0] bx;
        logic signed [17:0] by;
        logic signed [17:0] bw;
        logic signed [17:0] bh;
        ax = $signed({{2{a.x[15]}}, a.x});
        ay = $signed({{2{a.y[15]}}, a.y});
        aw = $signed({3'b000, a.w});
        ah = $signed({3'b000, a.h});
        bx = $signed({{2{b.x[15]}}, b.x});
        by = $signed({{2{b.y[15]}}, b.y});
        bw = $signed({3'b000, b.w});
        bh = $signed({3'b000, b.h});
        return (ax <= bx + bw) && (ax + aw >= bx) && (ay <= by + bh) && (ay + ah >= by);
    endfunction

    t_state                 r_state;
    t_state                 n_state;
    logic [TABLE_SLOTS-1:0] r_used;
    logic [TABLE_SLOTS-1:0] n_used;
    logic [TABLE_SLOTS-1:0] r_pend;
    logic [TABLE_SLOTS-1:0] n_pend;
    logic [IDX_W-1:0]       r_i;
    logic [IDX_W-1:0]       n_i;
    logic [IDX_W-1:0]       r_k;
    logic [IDX_W-1:0]       n_k;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [MASK_W-1:0]      r_mask;

    t_entry                 r_mem [TABLE_SLOTS];
    t_entry                 r_rd_a;
    t_entry                 r_rd_b;
    logic                   mem_we;

    logic                   r_out_valid;
    logic                   n_out_valid;
    t_status                r_status;
    t_status                n_status;
    logic [3:0]             r_given;
    logic [3:0]             n_given;
    logic [3:0]             r_first;
    logic [3:0]             n_first;
    logic [3:0]             r_second;
    logic [3:0]             n_second;
    logic                   r_fr;
    logic                   n_fr;
    logic                   r_sr;
    logic                   n_sr;
    logic                   r_last;
    logic                   n_last;

    logic                   out_free;
    logic                   has_free;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       mark_idx;
    logic                   fr;
    logic                   sr;
    logic                   hit;
    logic                   last_pair;

    always_comb begin
        has_free = 1'b0;
        free_idx = '0;
        for (int j = TABLE_SLOTS - 1; j >= 0; j--) begin
            if (!r_used[j]) begin
                has_free = 1'b1;
                free_idx = IDX_W'(j);
            end
        end
    end

    always_comb begin
        out_free  = !r_out_valid || i_out_ready;
        mark_idx  = i_item.slot[IDX_W-1:0];
        fr        = r_mask[{r_rd_a.kind, r_rd_b.kind}] & r_rd_a.notify;
        sr        = r_mask[{r_rd_b.kind, r_rd_a.kind}] & r_rd_b.notify;
        hit       = r_used[r_i] && r_used[r_k] && (fr || sr) &&
                    (r_cnt < CNT_W'(MAX_PAIR_ITEMS)) && f_overlap(r_rd_a, r_rd_b);
        last_pair = (r_i == IDX_W'(TABLE_SLOTS - 2)) && (r_k == IDX_W'(TABLE_SLOTS - 1));

        n_state     = r_state;
        n_used      = r_used;
        n_pend      = r_pend;
        n_i         = r_i;
        n_k         = r_k;
        n_cnt       = r_cnt;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_given     = r_given;
        n_first     = r_first;
        n_second    = r_second;
        n_fr        = r_fr;
        n_sr        = r_sr;
        n_last      = r_last;

        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty && out_free) begin
                    o_pop = 1'b1;
                    case (i_item.op)
                        CMD_ADD: begin
                            n_out_valid = 1'b1;
                            n_given     = '0;
                            n_first     = '0;
                            n_second    = '0;
                            n_fr        = 1'b0;
                            n_sr        = 1'b0;
                            n_last      = 1'b1;
                            if (has_free) begin
                                mem_we           = 1'b1;
                                n_used[free_idx] = 1'b1;
                                n_pend[free_idx] = 1'b0;
                                n_status         = ST_ADDED;
                                n_given          = 4'(free_idx);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_MARK: begin
                            if ((i_item.slot < 4'(TABLE_SLOTS)) && r_used[mark_idx]) begin
                                n_pend[mark_idx] = 1'b1;
                            end
                            n_out_valid = 1'b1;
                            n_status    = ST_MARKED;
                            n_given     = '0;
                            n_first     = '0;
                            n_second    = '0;
                            n_fr        = 1'b0;
                            n_sr        = 1'b0;
                            n_last      = 1'b1;
                        end
                        CMD_SCAN: begin
                            n_used  = r_used & ~r_pend;
                            n_pend  = '0;
                            n_i     = '0;
                            n_k     = IDX_W'(1);
                            n_cnt   = '0;
                            n_state = S_PAIR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAIR: begin
                if (hit && out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_PAIR;
                    n_given     = '0;
                    n_first     = 4'(r_i);
                    n_second    = 4'(r_k);
                    n_fr        = fr;
                    n_sr        = sr;
                    n_last      = 1'b0;
                    n_cnt       = r_cnt + CNT_W'(1);
                end
                if (!hit || out_free) begin
                    if (last_pair) begin
                        n_state = S_DONE;
                    end else if (r_k == IDX_W'(TABLE_SLOTS - 1)) begin
                        n_i = r_i + IDX_W'(1);
                        n_k = n_i + IDX_W'(1);
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_given     = '0;
                    n_first     = '0;
                    n_second    = '0;
                    n_fr        = 1'b0;
                    n_sr        = 1'b0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pend      <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_i         <= n_i;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[free_idx] <= i_item.entry;
        end
        r_rd_a   <= r_mem[n_i];
        r_rd_b   <= r_mem[n_k];
        r_status <= n_status;
        r_given  <= n_given;
        r_first  <= n_first;
        r_second <= n_second;
        r_fr     <= n_fr;
        r_sr     <= n_sr;
        r_last   <= n_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_given_slot      = r_given;
    assign o_first_index     = r_first;
    assign o_second_index    = r_second;
    assign o_first_reported  = r_fr;
    assign o_second_reported = r_sr;
    assign o_last            = r_last;

endmodule
`default_nettype wire

// File: src/rect_overlap_pair_scanner.sv
// Top level of the rectangle overlap pair scanner: front end, queue, table engine.
// Add and mark: queued, then popped and the result registered; one per cycle while
// the output is not stalled. Scan: the pop frees marked slots, then the 28 pairs for
// 8 slots are checked in turn, then the done item; results wait on output stalls.
// A two-entry queue lets input transfers continue while the engine works.
// Synchronous active-low reset clears occupancy, marks, mask, queue and output
// valid; rectangle contents stay undefined until written.
`default_nettype none
module rect_overlap_pair_scanner (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rops_pkg::MASK_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_command,
    input  wire logic signed [15:0]          i_rect_x,
    input  wire logic signed [15:0]          i_rect_y,
    input  wire logic [14:0]                 i_rect_w,
    input  wire logic [14:0]                 i_rect_h,
    input  wire logic [2:0]                  i_kind,
    input  wire logic                        i_notify,
    input  wire logic [3:0]                  i_slot,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [2:0]                       o_status,
    output logic [3:0]                       o_given_slot,
    output logic [3:0]                       o_first_index,
    output logic [3:0]                       o_second_index,
    output logic                             o_first_reported,
    output logic                             o_second_reported,
    output logic                             o_last
);
    import rops_pkg::*;

    t_q_stat q_stat;
    t_item   push_item;
    t_item   head_item;
    logic    push;
    logic    pop;

    rops_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_rect_x   (i_rect_x),
        .i_rect_y   (i_rect_y),
        .i_rect_w   (i_rect_w),
        .i_rect_h   (i_rect_h),
        .i_kind     (i_kind),
        .i_notify   (i_notify),
        .i_slot     (i_slot),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_item     (push_item)
    );

    rops_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    rops_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_q_stat          (q_stat),
        .i_item            (head_item),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_given_slot      (o_given_slot),
        .o_first_index     (o_first_index),
        .o_second_index    (o_second_index),
        .o_first_reported  (o_first_reported),
        .o_second_reported (o_second_reported),
        .o_last            (o_last)
    );

endmodule
`default_nettype wire

// File: src/rops_checker.sv
// Port-level assertions for the rectangle overlap pair scanner, bound to the top level.
`default_nettype none
module rops_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] o_status,
    input wire logic [3:0] o_first_index,
    input wire logic [3:0] o_second_index,
    input wire logic       o_first_reported,
    input wire logic       o_second_reported,
    input wire logic       o_last
);
    import rops_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_status) && $stable(o_first_index) &&
        $stable(o_second_index) && $stable(o_last))
        else $error("stalled result changed");

    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_PAIR) |->
        (o_first_index < o_second_index) && (o_first_reported || o_second_reported) &&
        !o_last)
        else $error("malformed pair result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind rect_overlap_pair_scanner rops_checker u_rops_checker (.*);
`default_nettype wire
